[hdl/fis_pkg.sv]
// ----------------------------------------------------------------------------
// fis_pkg: shared types and constants of the float insertion sorter
// Depth of the cell chain, word types and the float order key.
// ----------------------------------------------------------------------------
package fis_pkg;

    localparam int Depth = 64;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_item;
    } t_in_word;

    typedef struct packed {
        logic [31:0] sorted_value;
        logic        last_result;
        logic        overflow;
    } t_out_word;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic        ins;
        logic        shl;
        logic        clr;
        logic [31:0] key;
        logic [31:0] value;
    } t_cell_ctl;

    // unsigned key whose order is the numeric order, both zeros alike
    function automatic logic [31:0] order_key(input logic [31:0] bits);
        logic [31:0] b;
        b = (bits[30:0] == 31'd0) ? 32'd0 : bits;
        return b[31] ? ~b : (b | 32'h8000_0000);
    endfunction

endpackage

[hdl/fis_cell.sv]
// ----------------------------------------------------------------------------
// fis_cell: one cell of the insertion chain
// Holds one value; on insert keeps, takes the new value or takes the left
// neighbor's value; on emit shifts toward the output end.
// ----------------------------------------------------------------------------
module fis_cell
    import fis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctl   i_ctl,
    input  logic        i_left_valid,
    input  logic        i_left_gt,
    input  logic [31:0] i_left_value,
    input  logic        i_right_valid,
    input  logic [31:0] i_right_value,
    output logic        o_valid,
    output logic        o_gt,
    output logic [31:0] o_value
);
    logic [31:0] r_value, r_key;
    logic        r_valid;
    logic        w_gt;

    assign w_gt    = r_valid && (r_key > i_ctl.key);
    assign o_valid = r_valid;
    assign o_gt    = w_gt;
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shl) begin
            r_valid <= i_right_valid;
            r_value <= i_right_value;
            r_key   <= order_key(i_right_value);
        end else if (i_ctl.ins) begin
            if (i_left_gt) begin
                // everything from here on moves one place right
                r_valid <= i_left_valid;
                r_value <= i_left_value;
                r_key   <= order_key(i_left_value);
            end else if (w_gt || (!r_valid && i_left_valid)) begin
                // only the first cell holding a greater word, or the first empty cell, takes the new word
                r_valid <= 1'b1;
                r_value <= i_ctl.value;
                r_key   <= i_ctl.key;
            end
        end
    end
endmodule

[hdl/float_insertion_sorter.sv]
// ----------------------------------------------------------------------------
// float_insertion_sorter: systolic insertion sorter for float32 words
// Inserts one word per cycle while not busy into a chain of cells, emits ascending on last.
// ----------------------------------------------------------------------------
// channel  | dir | ports                         | handshake
// input    | in  | i_start, i_in (t_in_word)     | taken when i_start && !o_busy
// result   | out | o_strobe, o_out (t_out_word)  | one cycle per word, no stall
//
// a word is inserted in the cycle it is taken; next word may follow at once
// a last word is inserted unless the chain is full, then the held words leave
// one per cycle from cell 0 while busy is high
// synchronous active-low reset empties every cell and the drop flag
module float_insertion_sorter
    import fis_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_word  i_in,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out_word o_out
);
    localparam logic ST_FILL = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state;
    logic             r_drop;
    logic             w_take;
    t_cell_ctl        w_ctl;
    logic [Depth:0]   w_valid;
    logic [Depth-1:0] w_gt;
    logic [31:0]      w_val [Depth+1];
    logic             w_full;

    assign w_take = i_start && !o_busy;
    assign w_full = w_valid[Depth-1];
    assign o_busy = (r_state == ST_EMIT);

    assign w_ctl.ins   = w_take && !w_full;
    assign w_ctl.shl   = (r_state == ST_EMIT);
    assign w_ctl.clr   = 1'b0;
    assign w_ctl.key   = order_key(i_in.value_bits);
    assign w_ctl.value = i_in.value_bits;

    // right end of the chain feeds empty words
    assign w_valid[Depth] = 1'b0;
    assign w_val[Depth]   = 32'd0;

    genvar g;
    generate
        for (g = 0; g < Depth; g++) begin : g_cell
            logic        w_lv, w_lg;
            logic [31:0] w_lval;
            if (g == 0) begin : g_first
                // cell 0 may always take the new word
                assign w_lv = 1'b1;
                assign w_lg = 1'b0;
                assign w_lval = 32'd0;
            end else begin : g_rest
                assign w_lv = w_valid[g-1];
                assign w_lg = w_gt[g-1];
                assign w_lval = w_val[g-1];
            end
            fis_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_left_valid (w_lv),
                .i_left_gt    (w_lg),
                .i_left_value (w_lval),
                .i_right_valid(w_valid[g+1]),
                .i_right_value(w_val[g+1]),
                .o_valid      (w_valid[g]),
                .o_gt         (w_gt[g]),
                .o_value      (w_val[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_drop  <= 1'b0;
        end else begin
            case (r_state)
                ST_FILL: begin
                    if (w_take && w_full) r_drop <= 1'b1;
                    if (w_take && i_in.last_item) r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    // cell 1 empty means this is the final word
                    if (!w_valid[1]) begin
                        r_state <= ST_FILL;
                        r_drop  <= 1'b0;
                    end
                end
                default: r_state <= ST_FILL;
            endcase
        end
    end

    assign o_strobe           = (r_state == ST_EMIT);
    assign o_out.sorted_value = w_val[0];
    assign o_out.last_result  = !w_valid[1];
    assign o_out.overflow     = r_drop;
endmodule

[hdl/fis_checker.sv]
// ----------------------------------------------------------------------------
// fis_checker: port-level checks of the float insertion sorter
// Watches the handshake and the framing of result words.
// ----------------------------------------------------------------------------
module fis_checker
    import fis_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input t_in_word  i_in,
    input logic      o_busy,
    input logic      o_strobe,
    input t_out_word o_out
);
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy) else $error("strobe outside busy");
    a_end_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last_result) |=> !o_busy) else $error("busy after last");
    a_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out.last_result) |=> o_strobe) else $error("gap in batch");
    a_ovf_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out.last_result) |=> $stable(o_out.overflow))
        else $error("overflow changed in batch");
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.last_item) |=> o_strobe)
        else $error("no emission after last");
endmodule

bind float_insertion_sorter fis_checker u_fis_checker (.*);

[test/tb_float_insertion_sorter.sv]
// ----------------------------------------------------------------------------
// tb_float_insertion_sorter: regression bench for the float insertion sorter
// Drives batches of float words, predicts the ascending emission with a model
// of the cell chain and compares every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_float_insertion_sorter;
    import fis_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_word  i_in;
    logic      o_busy;
    logic      o_strobe;
    t_out_word o_out;

    float_insertion_sorter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_strobe(o_strobe),
        .o_out   (o_out)
    );

    // predictor state: the held words in ascending order and the drop flag
    logic [31:0] held_words[$];
    logic        batch_dropped;
    t_out_word   sorted_queue[$];
    int          mismatch_count;

    typedef struct {
        logic [31:0] value_bits;
        logic        last_item;
        logic        typed;      // expected words typed in below
        logic [31:0] exp_value;
        logic        exp_ovf;
    } t_row;

    t_row directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("float_insertion_sorter regression: fail");
        $finish;
    end

    function automatic logic [31:0] float_rank(input logic [31:0] bits);
        logic [31:0] b;
        b = (bits[30:0] == 31'd0) ? 32'd0 : bits;
        if (b[31]) begin
            return ~b;
        end
        return b | 32'h8000_0000;
    endfunction

    // insert after every held word not greater; emit the store on a last word
    task automatic predict_sort(input t_in_word w);
        int pos;
        if (held_words.size() >= Depth) begin
            batch_dropped = 1'b1;
        end else begin
            pos = held_words.size();
            while (pos > 0 && float_rank(held_words[pos-1]) > float_rank(w.value_bits)) begin
                pos--;
            end
            held_words.insert(pos, w.value_bits);
        end
        if (w.last_item) begin
            foreach (held_words[i]) begin
                sorted_queue.push_back('{sorted_value: held_words[i],
                                         last_result: (i == held_words.size() - 1),
                                         overflow: batch_dropped});
            end
            held_words.delete();
            batch_dropped = 1'b0;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_strobe) begin
            if (sorted_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected word %h", o_out);
                end
            end else begin
                exp_w = sorted_queue.pop_front();
                if (o_out.sorted_value !== exp_w.sorted_value
                        || o_out.last_result !== exp_w.last_result
                        || o_out.overflow !== exp_w.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                 exp_w.sorted_value, exp_w.last_result, exp_w.overflow,
                                 o_out.sorted_value, o_out.last_result, o_out.overflow);
                    end
                end
            end
        end
    end

    // start stays high after the word is taken; the caller drops it when idling
    task automatic send_word(input logic [31:0] v, input logic last);
        i_start <= 1'b1;
        i_in    <= '{value_bits: v, last_item: last};
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_sort('{value_bits: v, last_item: last});
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = {$urandom_range(0, 1) == 1, 31'd0};                  // signed zero
            1: v = {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};           // infinity
            2: v = {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};    // subnormal
            3: v = {$urandom_range(0, 1) == 1, 8'd127, 23'($urandom_range(0, 3))};
            default: v = $urandom;
        endcase
        // keep NaNs out
        if (v[30:23] == 8'hFF && v[22:0] != 0) v[22:0] = 23'd0;
        return v;
    endfunction

    task automatic wait_drain();
        i_start <= 1'b0;
        while (sorted_queue.size() != 0) @(posedge i_clk);
        repeat (Depth + 4) @(posedge i_clk);
    endtask

    initial begin
        int n_items;
        int blen;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_in           = '0;
        batch_dropped  = 1'b0;
        mismatch_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single words: the emitted word is the input itself
        directed_rows = '{
            '{32'h0000_0000, 1, 1, 32'h0000_0000, 0},
            '{32'h8000_0000, 1, 1, 32'h8000_0000, 0},
            '{32'hFFFF_FFFF & 32'hFF80_0000, 1, 1, 32'hFF80_0000, 0},
            '{32'h7F80_0000, 1, 1, 32'h7F80_0000, 0},
            '{32'h7F7F_FFFF, 1, 1, 32'h7F7F_FFFF, 0},
            '{32'h0000_0001, 1, 1, 32'h0000_0001, 0},
            // zeros of both signs keep arrival order, mixed signs and infinities
            '{32'h8000_0000, 0, 0, 0, 0},
            '{32'h3F80_0000, 0, 0, 0, 0},
            '{32'h0000_0000, 0, 0, 0, 0},
            '{32'hBF80_0000, 0, 0, 0, 0},
            '{32'h7F80_0000, 0, 0, 0, 0},
            '{32'hFF80_0000, 0, 0, 0, 0},
            '{32'h8000_0001, 0, 0, 0, 0},
            '{32'h3F80_0000, 1, 0, 0, 0}
        };
        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].value_bits, directed_rows[r].last_item);
            if (directed_rows[r].typed) begin
                if (sorted_queue.size() != 1
                        || sorted_queue[0].sorted_value !== directed_rows[r].exp_value
                        || sorted_queue[0].overflow !== directed_rows[r].exp_ovf) begin
                    mismatch_count++;
                    $display("directed row %0d predicts wrong word", r);
                end
            end
            idle_gap();
        end

        // full store: the last word is dropped but still triggers emission
        for (int i = 0; i < Depth + 2; i++) begin
            send_word(rand_float(), i == Depth + 1);
        end
        if (sorted_queue.size() < Depth || !sorted_queue[0].overflow) begin
            mismatch_count++;
            $display("overflow batch predicts wrong words");
        end
        wait_drain();

        // random batches, mostly short, a few filling the store
        n_items = 0;
        while (n_items < 280) begin
            blen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                              : $urandom_range(1, 12);
            for (int i = 0; i < blen; i++) begin
                send_word(rand_float(), i == blen - 1);
                n_items++;
                idle_gap();
            end
            if ($urandom_range(0, 7) == 0) begin
                i_start <= 1'b0;
                while (sorted_queue.size() != 0) @(posedge i_clk);
            end
        end

        wait_drain();
        if (mismatch_count == 0) begin
            $display("float_insertion_sorter regression: pass");
        end else begin
            $display("float_insertion_sorter regression: fail");
        end
        $finish;
    end

endmodule

[float_insertion_sorter.f]
hdl/fis_pkg.sv
hdl/fis_cell.sv
hdl/float_insertion_sorter.sv
hdl/fis_checker.sv
test/tb_float_insertion_sorter.sv
